[src/clpd_pkg.sv]
`timescale 1ns / 1ps

package clpd_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMD_W  = 3;
	localparam int SYM_W  = 8;
	localparam int STAT_W = 3;

	localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP_FWD = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUMP_REV = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

	localparam logic [STAT_W-1:0] ST_ITEM     = 3'd0;
	localparam logic [STAT_W-1:0] ST_PUSHED   = 3'd1;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;
	localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd6;

	typedef struct packed {
		logic              latch;
		logic              push_wr;
		logic              clr;
		logic              rd;
		logic              cmp;
		logic              commit_rm;
		logic              load;
		logic [STAT_W-1:0] status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             empty;
		logic             full;
		logic             rd_done;
		logic             rvalid;
		logic             none_rm;
		logic             slot_free;
		logic [CMD_W-1:0] cmd;
	} dp_stat_t;

endpackage

[src/clpd_if.sv]
`timescale 1ns / 1ps

interface clpd_in_if;
	logic                          valid;
	logic                          ready;
	logic [clpd_pkg::CMD_W-1:0]    command;
	logic [clpd_pkg::SYM_W-1:0]    symbol;

	modport source (output valid, command, symbol, input ready);
	modport sink (input valid, command, symbol, output ready);
endinterface

interface clpd_out_if;
	logic                          valid;
	logic                          ready;
	logic [clpd_pkg::SYM_W-1:0]    symbol_out;
	logic [clpd_pkg::STAT_W-1:0]   status;
	logic [clpd_pkg::CNT_W-1:0]    removed_count;
	logic                          last;

	modport source (output valid, symbol_out, status, removed_count, last, input ready);
	modport sink (input valid, symbol_out, status, removed_count, last, output ready);
endinterface

[src/clpd_ctrl.sv]
`timescale 1ns / 1ps

module clpd_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [clpd_pkg::CMD_W-1:0] in_command,
	output logic                       in_ready,
	input  clpd_pkg::dp_stat_t         st,
	output clpd_pkg::ctrl_cmd_t        cmd
);
	import clpd_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ONE  = 3'd1;
	localparam logic [2:0] S_RM   = 3'd2;
	localparam logic [2:0] S_DRD  = 3'd3;
	localparam logic [2:0] S_DLD  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (in_command)
						CMD_PUSH, CMD_CLEAR: state_nxt = S_ONE;
						CMD_REMOVE: state_nxt = S_RM;
						CMD_DUMP_FWD, CMD_DUMP_REV: state_nxt = st.empty ? S_ONE : S_DRD;
						default: state_nxt = S_IDLE;
					endcase
				end
			end
			S_RM: begin
				// the compare/write handles each entry in the cycle after the read cursor fetches it
				cmd.rd  = !st.rd_done;
				cmd.cmp = st.rvalid;
				if (st.rd_done && !st.rvalid) begin
					state_nxt = S_ONE;
				end
			end
			S_ONE: begin
				if (st.slot_free) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
					case (st.cmd)
						CMD_PUSH: begin
							if (st.full) begin
								cmd.status = ST_FULL;
							end else begin
								cmd.push_wr = 1'b1;
								cmd.status  = ST_PUSHED;
							end
						end
						CMD_REMOVE: begin
							cmd.commit_rm = 1'b1;
							cmd.status    = st.none_rm ? ST_NOTFOUND : ST_REMOVED;
						end
						CMD_CLEAR: begin
							cmd.clr    = 1'b1;
							cmd.status = ST_CLEARED;
						end
						default: cmd.status = ST_EMPTY;
					endcase
				end
			end
			S_DRD: begin
				cmd.rd    = 1'b1;
				state_nxt = S_DLD;
			end
			S_DLD: begin
				if (st.slot_free) begin
					cmd.load   = 1'b1;
					cmd.status = ST_ITEM;
					state_nxt  = st.rd_done ? S_IDLE : S_DRD;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

[src/clpd_dpath.sv]
`timescale 1ns / 1ps

module clpd_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [clpd_pkg::CMD_W-1:0] in_command,
	input  logic [clpd_pkg::SYM_W-1:0] in_symbol,
	input  clpd_pkg::ctrl_cmd_t        cmd,
	output clpd_pkg::dp_stat_t         st,
	clpd_out_if.source                 out_ch
);
	import clpd_pkg::*;

	// Physical slot 0 holds the oldest entry (back of the list), so a push
	// appends at slot cnt_q and never shifts.
	logic [SYM_W-1:0]  mem [DEPTH];
	logic [SYM_W-1:0]  rdata_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  wr_ptr_q;
	logic              rvalid_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [SYM_W-1:0]  sym_q;
	logic              out_valid_q;
	logic [SYM_W-1:0]  out_sym_q;
	logic [STAT_W-1:0] out_status_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;
	logic [CNT_W-1:0]  rd_pos;
	logic [ADDR_W-1:0] rd_addr;
	logic              keep;

	assign rd_pos  = (cmd_q == CMD_DUMP_FWD) ? (cnt_q - idx_q - CNT_W'(1)) : idx_q;
	assign rd_addr = rd_pos[ADDR_W-1:0];
	assign keep    = (rdata_q != sym_q);

	assign st.empty     = (cnt_q == '0);
	assign st.full      = (cnt_q == CNT_W'(DEPTH));
	assign st.rd_done   = (idx_q == cnt_q);
	assign st.rvalid    = rvalid_q;
	assign st.none_rm   = (wr_ptr_q == cnt_q);
	assign st.slot_free = !out_valid_q || out_ch.ready;
	assign st.cmd       = cmd_q;

	always_ff @(posedge clk) begin
		if (cmd.push_wr) begin
			mem[cnt_q[ADDR_W-1:0]] <= sym_q;
		end else if (cmd.cmp && keep) begin
			mem[wr_ptr_q[ADDR_W-1:0]] <= rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= in_command;
			sym_q <= in_symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			idx_q    <= '0;
			wr_ptr_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= cmd.rd;
			if (cmd.latch) begin
				idx_q    <= '0;
				wr_ptr_q <= '0;
			end else begin
				if (cmd.rd) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (cmd.cmp && keep) begin
					wr_ptr_q <= wr_ptr_q + CNT_W'(1);
				end
			end
			if (cmd.push_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.clr) begin
				cnt_q <= '0;
			end else if (cmd.commit_rm) begin
				cnt_q <= wr_ptr_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= cmd.status;
			out_sym_q    <= (cmd.status == ST_ITEM) ? rdata_q : '0;
			out_cnt_q    <= (cmd.status == ST_REMOVED) ? (cnt_q - wr_ptr_q) : '0;
			out_last_q   <= (cmd.status == ST_ITEM) ? st.rd_done : 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.symbol_out    = out_sym_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.removed_count = out_cnt_q;
	assign out_ch.last          = out_last_q;

endmodule

[src/char_list_push_remove_dump_top.sv]
`timescale 1ns / 1ps

// Ordered byte list, newest entry at the front, up to DEPTH (64) entries.
// in_ch takes one command word: push, remove all matches, dump forward,
// dump reverse or clear; codes 5 to 7 are taken and dropped with no result.
// out_ch returns result words; last marks the final word of each command.
// in_ch.ready is high only while no command is in progress, so commands
// are handled one at a time.
// Push, clear and an empty dump each produce one result word. Remove
// compacts the list in place: it reads one entry a cycle from the byte
// memory and writes the kept ones back in the cycle after, then loads its
// result. A dump reads each entry from memory, then loads it into the
// output register, before it reads the next entry.
// A result waits in the output register while out_ch.ready is low; the
// command then holds its place and resumes when the word is taken.
// Reset empties the list and drops any pending result word; the byte
// memory itself is not cleared and needs no clearing pass.
module char_list_push_remove_dump_top (
	input logic        clk,
	input logic        arst_n,
	clpd_in_if.sink    in_ch,
	clpd_out_if.source out_ch
);
	import clpd_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  st;

	clpd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.st         (st),
		.cmd        (cmd)
	);

	clpd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_command (in_ch.command),
		.in_symbol  (in_ch.symbol),
		.cmd        (cmd),
		.st         (st),
		.out_ch     (out_ch)
	);

endmodule

[src/clpd_chk.sv]
`timescale 1ns / 1ps

module clpd_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [clpd_pkg::SYM_W-1:0]  symbol_out,
	input logic [clpd_pkg::STAT_W-1:0] status,
	input logic [clpd_pkg::CNT_W-1:0]  removed_count,
	input logic                        last
);
	import clpd_pkg::*;

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(symbol_out) && $stable(status)
			&& $stable(removed_count) && $stable(last))
		else $error("stalled result word changed");

	// a dump in progress must not take a new command
	a_busy_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("command taken during a dump");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_ITEM |-> last && symbol_out == '0)
		else $error("status word not final or carries a byte");

	a_removed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_REMOVED) == (removed_count != '0)))
		else $error("removed count inconsistent with status");

endmodule

bind char_list_push_remove_dump_top clpd_chk u_clpd_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.symbol_out    (out_ch.symbol_out),
	.status        (out_ch.status),
	.removed_count (out_ch.removed_count),
	.last          (out_ch.last)
);
